[rtl/ptd_pkg.sv]
// ----------------------------------------------------------------------------
// ptd_pkg
// shared constants and types for the point to triangle distance pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

  // width of the squared distance result, an integer with no fractional bits
  localparam int DIST_WIDTH = 42;

  // closest feature of the triangle
  typedef enum logic [2:0] {
    REGION_A    = 3'd0,
    REGION_B    = 3'd1,
    REGION_AB   = 3'd2,
    REGION_C    = 3'd3,
    REGION_AC   = 3'd4,
    REGION_BC   = 3'd5,
    REGION_FACE = 3'd6
  } region_e;

endpackage

`default_nettype wire

[rtl/ptd_delay.sv]
// ----------------------------------------------------------------------------
// ptd_delay
// fixed-length register delay line for side data of the pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  wire logic         clk_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] dly_q [0:N-1];

  always_ff @(posedge clk_i) begin
    dly_q[0] <= d_i;
    for (int i = 1; i < N; i++) begin
      dly_q[i] <= dly_q[i-1];
    end
  end

  assign q_o = dly_q[N-1];

endmodule

`default_nettype wire

[rtl/ptd_mul.sv]
// ----------------------------------------------------------------------------
// ptd_mul
// two-stage signed multiplier built from four half-width partial products
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_mul #(
  parameter int AW = 44,
  parameter int BW = 44
) (
  input  wire logic                  clk_i,
  input  wire logic signed [AW-1:0]  a_i,
  input  wire logic signed [BW-1:0]  b_i,
  output logic signed [AW+BW-1:0]    p_o
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic signed [AH-1:0]    a_hi;
  logic        [AL-1:0]    a_lo;
  logic signed [BH-1:0]    b_hi;
  logic        [BL-1:0]    b_lo;

  logic signed [AH+BH-1:0] hh_d, hh_q;
  logic signed [AH+BL:0]   hl_d, hl_q;
  logic signed [AL+BH:0]   lh_d, lh_q;
  logic        [AL+BL-1:0] ll_d, ll_q;

  logic signed [PW-1:0]    x_hh, x_hl, x_lh, x_ll;
  logic signed [PW-1:0]    p_d, p_q;

  assign a_hi = a_i[AW-1:AL];
  assign a_lo = a_i[AL-1:0];
  assign b_hi = b_i[BW-1:BL];
  assign b_lo = b_i[BL-1:0];

  // partial products
  assign hh_d = a_hi * b_hi;
  assign hl_d = a_hi * $signed({1'b0, b_lo});
  assign lh_d = $signed({1'b0, a_lo}) * b_hi;
  assign ll_d = a_lo * b_lo;

  always_ff @(posedge clk_i) begin
    hh_q <= hh_d;
    hl_q <= hl_d;
    lh_q <= lh_d;
    ll_q <= ll_d;
  end

  // recombine
  assign x_hh = PW'(hh_q);
  assign x_hl = PW'(hl_q);
  assign x_lh = PW'(lh_q);
  assign x_ll = $signed(PW'(ll_q));
  assign p_d  = (x_hh <<< (AL + BL)) + (x_hl <<< AL) + (x_lh <<< BL) + x_ll;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[rtl/ptd_div.sv]
// ----------------------------------------------------------------------------
// ptd_div
// pipelined restoring divider giving a ratio clamped to [0, 1]
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_div #(
  parameter int NW = 91,
  parameter int R  = 24
) (
  input  wire logic                 clk_i,
  input  wire logic signed [NW-1:0] num_i,
  input  wire logic signed [NW-1:0] den_i,
  output logic             [R:0]    ratio_o,
  output logic                      zero_o
);

  // prep stage: magnitudes and special cases
  logic          zero_d, zero_q;
  logic          force_d, force_q;
  logic [NW-1:0] anum_d, anum_q;
  logic [NW-1:0] aden_d, aden_q;

  assign zero_d  = (den_i == '0);
  assign force_d = zero_d || (num_i == '0) || (num_i[NW-1] != den_i[NW-1]);
  assign anum_d  = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
  assign aden_d  = den_i[NW-1] ? NW'(-den_i) : NW'(den_i);

  always_ff @(posedge clk_i) begin
    zero_q  <= zero_d;
    force_q <= force_d;
    anum_q  <= anum_d;
    aden_q  <= aden_d;
  end

  // one quotient bit per stage, index 0 is the saturation check
  logic [NW-1:0] rem_q  [0:R];
  logic [NW-1:0] den_q  [0:R];
  logic [R-1:0]  quo_q  [0:R];
  logic          sat_q  [0:R];
  logic          frc_q  [0:R];
  logic          zer_q  [0:R];

  logic [NW:0]   two    [1:R];
  logic          ge     [1:R];

  always_comb begin
    for (int i = 1; i <= R; i++) begin
      two[i] = {rem_q[i-1], 1'b0};
      ge[i]  = (two[i] >= {1'b0, den_q[i-1]});
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q[0] <= (anum_q >= aden_q);
    rem_q[0] <= (anum_q >= aden_q) ? '0 : anum_q;
    den_q[0] <= aden_q;
    quo_q[0] <= '0;
    frc_q[0] <= force_q;
    zer_q[0] <= zero_q;
    for (int i = 1; i <= R; i++) begin
      rem_q[i] <= ge[i] ? NW'(two[i] - {1'b0, den_q[i-1]}) : NW'(two[i]);
      den_q[i] <= den_q[i-1];
      quo_q[i] <= {quo_q[i-1][R-2:0], ge[i]};
      sat_q[i] <= sat_q[i-1];
      frc_q[i] <= frc_q[i-1];
      zer_q[i] <= zer_q[i-1];
    end
  end

  always_comb begin
    if (frc_q[R]) begin
      ratio_o = '0;
    end else if (sat_q[R]) begin
      ratio_o = {1'b1, {R{1'b0}}};
    end else begin
      ratio_o = {1'b0, quo_q[R]};
    end
  end

  assign zero_o = zer_q[R];

endmodule

`default_nettype wire

[rtl/ptd_dist.sv]
// ----------------------------------------------------------------------------
// ptd_dist
// squared length of rel - t1*e1 - t2*e2, truncated and saturated
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_dist #(
  parameter int DW = 21,
  parameter int R  = 24
) (
  input  wire logic                               clk_i,
  input  wire logic [3*DW-1:0]                    rel_i,
  input  wire logic [3*DW-1:0]                    e1_i,
  input  wire logic [3*DW-1:0]                    e2_i,
  input  wire logic [R:0]                         t1_i,
  input  wire logic [R:0]                         t2_i,
  output logic      [ptd_pkg::DIST_WIDTH-1:0]     dist_o
);

  localparam int XW   = DW + R + 2;
  localparam int TPW  = R + 2 + DW;
  localparam int SUMW = 2 * XW + 2;
  localparam int SHW  = (SUMW - 2 * R > ptd_pkg::DIST_WIDTH) ? SUMW - 2 * R
                                                              : ptd_pkg::DIST_WIDTH;

  logic signed [XW-1:0]   rsh_q [0:2];
  logic signed [TPW-1:0]  p1_q  [0:2];
  logic signed [TPW-1:0]  p2_q  [0:2];
  logic signed [XW-1:0]   dif_q [0:2];
  logic signed [2*XW-1:0] sq    [0:2];

  logic [SUMW-1:0]                sum;
  logic [SHW-1:0]                 sh;
  logic [ptd_pkg::DIST_WIDTH-1:0] dist_d, dist_q;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      rsh_q[a] <= XW'($signed(rel_i[a*DW +: DW])) <<< R;
      p1_q[a]  <= $signed({1'b0, t1_i}) * $signed(e1_i[a*DW +: DW]);
      p2_q[a]  <= $signed({1'b0, t2_i}) * $signed(e2_i[a*DW +: DW]);
      dif_q[a] <= rsh_q[a] - XW'(p1_q[a]) - XW'(p2_q[a]);
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_sq
    ptd_mul #(
      .AW (XW),
      .BW (XW)
    ) u_sq (
      .clk_i (clk_i),
      .a_i   (dif_q[a]),
      .b_i   (dif_q[a]),
      .p_o   (sq[a])
    );
  end

  // squares are never negative
  assign sum = SUMW'($unsigned(sq[0])) + SUMW'($unsigned(sq[1]))
             + SUMW'($unsigned(sq[2]));
  assign sh  = SHW'(sum >> (2 * R));

  assign dist_d = (|(sh >> ptd_pkg::DIST_WIDTH)) ? '1 : sh[ptd_pkg::DIST_WIDTH-1:0];

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  assign dist_o = dist_q;

endmodule

`default_nettype wire

[rtl/point_triangle_distance_squared.sv]
// ----------------------------------------------------------------------------
// point_triangle_distance_squared
// squared distance from a point to a triangle and the closest feature
// ----------------------------------------------------------------------------
//  channel  | ports                                     | handshake
//  ---------+-------------------------------------------+--------------------
//  request  | point_*_i, vert_a_*_i, vert_b_*_i, vert_c_*_i | start && !busy
//  result   | dist_squared_o, region_o, degenerate_o    | done_o, one cycle
//
//  one beat per cycle in, one result beat per cycle out
//  the pipeline depth comes mainly from the divider (one ratio bit
//  per stage) plus the split multipliers of the minors and the squares
//  busy is always low: the pipeline never holds, every stage moves each cycle
//  reset clears only the valid bits; data registers carry no reset
//  the receiver cannot stall, so done_o marks the only cycle a result is shown
// ----------------------------------------------------------------------------
`default_nettype none

module point_triangle_distance_squared #(
  parameter int COORD_WIDTH     = 20,
  parameter int RATIO_FRAC_BITS = 24
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [COORD_WIDTH-1:0]      point_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]      point_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]      point_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]      vert_a_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]      vert_a_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]      vert_a_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]      vert_b_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]      vert_b_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]      vert_b_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]      vert_c_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]      vert_c_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]      vert_c_z_i,
  output logic                                    done_o,
  output logic [ptd_pkg::DIST_WIDTH-1:0]          dist_squared_o,
  output logic [2:0]                              region_o,
  output logic                                    degenerate_o
);

  localparam int R       = RATIO_FRAC_BITS;
  localparam int DW      = COORD_WIDTH + 1;  // coordinate differences
  localparam int PW      = 2 * DW;           // one dot product term
  localparam int SW      = PW + 2;           // dot product
  localparam int MPW     = 2 * SW;           // product of two dot products
  localparam int NW      = MPW + 3;          // minors and their sum
  localparam int DIVLAT  = R + 2;
  localparam int DISTLAT = 5;
  localparam int LAT     = 7 + DIVLAT + DISTLAT;

  // the pipeline never holds off a beat
  assign busy = 1'b0;

  // valid bits, one per stage
  logic vld_q [0:LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= start;
      for (int i = 1; i < LAT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: edge vectors and point offsets
  // slots: 0 ab, 1 ac, 2 bc, 3 ap, 4 bp, 5 cp; three axes each
  // ---------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] pt [0:2];
  logic signed [COORD_WIDTH-1:0] pa [0:2];
  logic signed [COORD_WIDTH-1:0] pb [0:2];
  logic signed [COORD_WIDTH-1:0] pc [0:2];
  logic [18*DW-1:0]              vec1_d, vec1_q;

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;
  assign pa[0] = vert_a_x_i;
  assign pa[1] = vert_a_y_i;
  assign pa[2] = vert_a_z_i;
  assign pb[0] = vert_b_x_i;
  assign pb[1] = vert_b_y_i;
  assign pb[2] = vert_b_z_i;
  assign pc[0] = vert_c_x_i;
  assign pc[1] = vert_c_y_i;
  assign pc[2] = vert_c_z_i;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      vec1_d[(0*3+a)*DW +: DW] = DW'(pb[a]) - DW'(pa[a]);
      vec1_d[(1*3+a)*DW +: DW] = DW'(pc[a]) - DW'(pa[a]);
      vec1_d[(2*3+a)*DW +: DW] = DW'(pc[a]) - DW'(pb[a]);
      vec1_d[(3*3+a)*DW +: DW] = DW'(pt[a]) - DW'(pa[a]);
      vec1_d[(4*3+a)*DW +: DW] = DW'(pt[a]) - DW'(pb[a]);
      vec1_d[(5*3+a)*DW +: DW] = DW'(pt[a]) - DW'(pc[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    vec1_q <= vec1_d;
  end

  // ---------------------------------------------------------------------
  // stages 2 and 3: six dot products, terms registered then summed
  // s1 ab.ap, s2 ac.ap, s3 ab.bp, s4 ac.bp, s5 ab.cp, s6 ac.cp
  // ---------------------------------------------------------------------
  logic signed [PW-1:0] prod_q [0:5][0:2];
  logic [6*SW-1:0]      s3_q;

  for (genvar k = 0; k < 6; k++) begin : g_dot
    localparam int LS = k % 2;
    localparam int RS = 3 + k / 2;
    for (genvar a = 0; a < 3; a++) begin : g_ax
      always_ff @(posedge clk_i) begin
        prod_q[k][a] <= $signed(vec1_q[(LS*3+a)*DW +: DW])
                      * $signed(vec1_q[(RS*3+a)*DW +: DW]);
      end
    end
    always_ff @(posedge clk_i) begin
      s3_q[k*SW +: SW] <= SW'(prod_q[k][0]) + SW'(prod_q[k][1]) + SW'(prod_q[k][2]);
    end
  end

  // ---------------------------------------------------------------------
  // stages 4 and 5: products for the barycentric minors
  // ---------------------------------------------------------------------
  logic signed [SW-1:0]  s3v  [0:5];
  logic signed [MPW-1:0] mp   [0:5];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      s3v[k] = $signed(s3_q[k*SW +: SW]);
    end
  end

  // pairs: s1*s4, s3*s2, s5*s2, s1*s6, s3*s6, s5*s4
  ptd_mul #(.AW(SW), .BW(SW)) u_m0 (.clk_i(clk_i), .a_i(s3v[0]), .b_i(s3v[3]), .p_o(mp[0]));
  ptd_mul #(.AW(SW), .BW(SW)) u_m1 (.clk_i(clk_i), .a_i(s3v[2]), .b_i(s3v[1]), .p_o(mp[1]));
  ptd_mul #(.AW(SW), .BW(SW)) u_m2 (.clk_i(clk_i), .a_i(s3v[4]), .b_i(s3v[1]), .p_o(mp[2]));
  ptd_mul #(.AW(SW), .BW(SW)) u_m3 (.clk_i(clk_i), .a_i(s3v[0]), .b_i(s3v[5]), .p_o(mp[3]));
  ptd_mul #(.AW(SW), .BW(SW)) u_m4 (.clk_i(clk_i), .a_i(s3v[2]), .b_i(s3v[5]), .p_o(mp[4]));
  ptd_mul #(.AW(SW), .BW(SW)) u_m5 (.clk_i(clk_i), .a_i(s3v[4]), .b_i(s3v[3]), .p_o(mp[5]));

  // ---------------------------------------------------------------------
  // stage 6: minors mc (area opposite c), mb, ma
  // ---------------------------------------------------------------------
  logic signed [NW-1:0] mc_q, mb_q, ma_q;
  logic [6*SW-1:0]      s6_q;
  logic [18*DW-1:0]     vec6_q;

  always_ff @(posedge clk_i) begin
    mc_q <= NW'(mp[0]) - NW'(mp[1]);
    mb_q <= NW'(mp[2]) - NW'(mp[3]);
    ma_q <= NW'(mp[4]) - NW'(mp[5]);
  end

  ptd_delay #(.W(6*SW), .N(3)) u_s_dly (
    .clk_i (clk_i),
    .d_i   (s3_q),
    .q_o   (s6_q)
  );

  ptd_delay #(.W(18*DW), .N(5)) u_vec_dly (
    .clk_i (clk_i),
    .d_i   (vec1_q),
    .q_o   (vec6_q)
  );

  // ---------------------------------------------------------------------
  // stage 7: region tests in the usual priority order, and the selection
  // of the ratio operands and the vectors for the distance
  // ---------------------------------------------------------------------
  logic signed [SW-1:0] s1, s2, s3, s4, s5, s6;
  logic signed [SW:0]   d43, d56;
  logic signed [NW-1:0] tot;
  logic [DW-1:0]        eab [0:2];
  logic [DW-1:0]        eac [0:2];
  logic [DW-1:0]        ebc [0:2];
  logic [DW-1:0]        rap [0:2];
  logic [DW-1:0]        rbp [0:2];
  logic [DW-1:0]        rcp [0:2];

  ptd_pkg::region_e     region_d;
  logic [9*DW-1:0]      sel_d;
  logic signed [NW-1:0] n0_d, d0_d, n1_d, d1_d;

  ptd_pkg::region_e     region7_q;
  logic [9*DW-1:0]      sel7_q;
  logic signed [NW-1:0] n0_q, d0_q, n1_q, d1_q;

  assign s1  = $signed(s6_q[0*SW +: SW]);
  assign s2  = $signed(s6_q[1*SW +: SW]);
  assign s3  = $signed(s6_q[2*SW +: SW]);
  assign s4  = $signed(s6_q[3*SW +: SW]);
  assign s5  = $signed(s6_q[4*SW +: SW]);
  assign s6  = $signed(s6_q[5*SW +: SW]);
  assign d43 = (SW+1)'(s4) - (SW+1)'(s3);
  assign d56 = (SW+1)'(s5) - (SW+1)'(s6);
  assign tot = ma_q + mb_q + mc_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      eab[a] = vec6_q[(0*3+a)*DW +: DW];
      eac[a] = vec6_q[(1*3+a)*DW +: DW];
      ebc[a] = vec6_q[(2*3+a)*DW +: DW];
      rap[a] = vec6_q[(3*3+a)*DW +: DW];
      rbp[a] = vec6_q[(4*3+a)*DW +: DW];
      rcp[a] = vec6_q[(5*3+a)*DW +: DW];
    end
  end

  always_comb begin
    region_d = ptd_pkg::REGION_FACE;
    sel_d    = '0;
    // unused ratios see 0 / 1: zero result, no flag
    n0_d     = '0;
    d0_d     = NW'(1);
    n1_d     = '0;
    d1_d     = NW'(1);
    if (s1 <= 0 && s2 <= 0) begin
      region_d = ptd_pkg::REGION_A;
      for (int a = 0; a < 3; a++) sel_d[a*DW +: DW] = rap[a];
    end else if (s3 >= 0 && s4 <= s3) begin
      region_d = ptd_pkg::REGION_B;
      for (int a = 0; a < 3; a++) sel_d[a*DW +: DW] = rbp[a];
    end else if (mc_q <= 0 && s1 >= 0 && s3 <= 0) begin
      region_d = ptd_pkg::REGION_AB;
      for (int a = 0; a < 3; a++) begin
        sel_d[a*DW +: DW]     = rap[a];
        sel_d[(3+a)*DW +: DW] = eab[a];
      end
      n0_d = NW'(s1);
      d0_d = NW'(s1) - NW'(s3);
    end else if (s6 >= 0 && s5 <= s6) begin
      region_d = ptd_pkg::REGION_C;
      for (int a = 0; a < 3; a++) sel_d[a*DW +: DW] = rcp[a];
    end else if (mb_q <= 0 && s2 >= 0 && s6 <= 0) begin
      region_d = ptd_pkg::REGION_AC;
      for (int a = 0; a < 3; a++) begin
        sel_d[a*DW +: DW]     = rap[a];
        sel_d[(3+a)*DW +: DW] = eac[a];
      end
      n0_d = NW'(s2);
      d0_d = NW'(s2) - NW'(s6);
    end else if (ma_q <= 0 && d43 >= 0 && d56 >= 0) begin
      region_d = ptd_pkg::REGION_BC;
      for (int a = 0; a < 3; a++) begin
        sel_d[a*DW +: DW]     = rbp[a];
        sel_d[(3+a)*DW +: DW] = ebc[a];
      end
      n0_d = NW'(d43);
      d0_d = NW'(d43) + NW'(d56);
    end else begin
      for (int a = 0; a < 3; a++) begin
        sel_d[a*DW +: DW]     = rap[a];
        sel_d[(3+a)*DW +: DW] = eab[a];
        sel_d[(6+a)*DW +: DW] = eac[a];
      end
      n0_d = mb_q;
      d0_d = tot;
      n1_d = mc_q;
      d1_d = tot;
    end
  end

  always_ff @(posedge clk_i) begin
    region7_q <= region_d;
    sel7_q    <= sel_d;
    n0_q      <= n0_d;
    d0_q      <= d0_d;
    n1_q      <= n1_d;
    d1_q      <= d1_d;
  end

  // ---------------------------------------------------------------------
  // ratio dividers, vectors and region ride alongside
  // ---------------------------------------------------------------------
  logic [R:0]         t1, t2;
  logic               z1, z2;
  logic [9*DW+2:0]    side_q;

  ptd_div #(.NW(NW), .R(R)) u_div0 (
    .clk_i   (clk_i),
    .num_i   (n0_q),
    .den_i   (d0_q),
    .ratio_o (t1),
    .zero_o  (z1)
  );

  ptd_div #(.NW(NW), .R(R)) u_div1 (
    .clk_i   (clk_i),
    .num_i   (n1_q),
    .den_i   (d1_q),
    .ratio_o (t2),
    .zero_o  (z2)
  );

  ptd_delay #(.W(9*DW+3), .N(DIVLAT)) u_side_dly (
    .clk_i (clk_i),
    .d_i   ({region7_q, sel7_q}),
    .q_o   (side_q)
  );

  // ---------------------------------------------------------------------
  // distance to the closest point
  // ---------------------------------------------------------------------
  logic [3:0] meta_q;

  ptd_dist #(.DW(DW), .R(R)) u_dist (
    .clk_i  (clk_i),
    .rel_i  (side_q[0 +: 3*DW]),
    .e1_i   (side_q[3*DW +: 3*DW]),
    .e2_i   (side_q[6*DW +: 3*DW]),
    .t1_i   (t1),
    .t2_i   (t2),
    .dist_o (dist_squared_o)
  );

  ptd_delay #(.W(4), .N(DISTLAT)) u_meta_dly (
    .clk_i (clk_i),
    .d_i   ({side_q[9*DW +: 3], z1 | z2}),
    .q_o   (meta_q)
  );

  assign done_o       = vld_q[LAT-1];
  assign region_o     = meta_q[3:1];
  assign degenerate_o = meta_q[0];

endmodule

`default_nettype wire

[verif/point_triangle_distance_squared_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_triangle_distance_squared_tb
// self-checking bench for the point to triangle squared distance pipeline
// ----------------------------------------------------------------------------
// every accepted beat is run through a local predictor that classifies the
// closest feature with exact integer dot products and minors, divides out the
// ratios and forms the truncated squared distance. the expected results are
// queued in order and each done_o beat is compared field by field with the
// oldest one. stimulus is a directed set (extremes, every region, degenerate
// triangles) followed by bursts of random triangles, mostly with nearby points
// ----------------------------------------------------------------------------
`default_nettype none

module point_triangle_distance_squared_tb;

  localparam int CW          = 20;
  localparam int RFB         = 24;
  localparam int LATENCY     = RFB + 14;
  localparam int CYCLE_LIMIT = 200000;
  localparam longint CMAX    = 524287;
  localparam longint CMIN    = -524288;

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [127:0]   wide_t;

  // one expected result beat
  typedef struct {
    logic [ptd_pkg::DIST_WIDTH-1:0] dsq;
    ptd_pkg::region_e               region;
    logic                           degen;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t drv_q [12];
  logic done_o;
  logic [ptd_pkg::DIST_WIDTH-1:0] dist_squared_o;
  logic [2:0] region_o;
  logic degenerate_o;

  outcome_t pending_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  initial begin
    for (int i = 0; i < 12; i++) drv_q[i] = '0;
  end

  point_triangle_distance_squared #(
    .COORD_WIDTH(CW),
    .RATIO_FRAC_BITS(RFB)
  ) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .point_x_i(drv_q[0]), .point_y_i(drv_q[1]), .point_z_i(drv_q[2]),
    .vert_a_x_i(drv_q[3]), .vert_a_y_i(drv_q[4]), .vert_a_z_i(drv_q[5]),
    .vert_b_x_i(drv_q[6]), .vert_b_y_i(drv_q[7]), .vert_b_z_i(drv_q[8]),
    .vert_c_x_i(drv_q[9]), .vert_c_y_i(drv_q[10]), .vert_c_z_i(drv_q[11]),
    .done_o(done_o), .dist_squared_o(dist_squared_o), .region_o(region_o),
    .degenerate_o(degenerate_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  function automatic longint dot3(longint x[3], longint y[3]);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  // ratio num/den at RFB fractional bits, truncated and clamped to [0, 1]
  function automatic longint ratio_of(wide_t num, wide_t den, inout logic zero_div);
    wide_t quo;
    if (den == 0) begin
      zero_div = 1'b1;
      return 0;
    end
    if (num == 0 || (num < 0) != (den < 0)) return 0;
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    quo = (num <<< RFB) / den;
    if (quo > (wide_t'(1) <<< RFB)) return longint'(1) <<< RFB;
    return longint'(quo);
  endfunction

  // |rel - t1*e1 - t2*e2|^2 brought back to an integer, saturating
  function automatic logic [ptd_pkg::DIST_WIDTH-1:0] sq_dist(longint rel[3], longint e1[3],
                                                             longint t1, longint e2[3],
                                                             longint t2);
    wide_t sum;
    longint diff;
    sum = 0;
    for (int ax = 0; ax < 3; ax++) begin
      diff = (rel[ax] <<< RFB) - t1 * e1[ax] - t2 * e2[ax];
      sum += wide_t'(diff) * wide_t'(diff);
    end
    sum = sum >>> (2 * RFB);
    if (sum > wide_t'({ptd_pkg::DIST_WIDTH{1'b1}})) return '1;
    return sum[ptd_pkg::DIST_WIDTH-1:0];
  endfunction

  function automatic outcome_t closest_feature(coord_t c[12]);
    longint pt[3], pa[3], pb[3], pc[3], nil[3];
    longint eab[3], eac[3], ebc[3], rap[3], rbp[3], rcp[3];
    longint s1, s2, s3, s4, s5, s6, ta, tb;
    wide_t mc, mb, ma;
    outcome_t o;
    o.degen = 1'b0;
    for (int ax = 0; ax < 3; ax++) begin
      pt[ax] = c[ax]; pa[ax] = c[3+ax]; pb[ax] = c[6+ax]; pc[ax] = c[9+ax];
      nil[ax] = 0;
      eab[ax] = pb[ax] - pa[ax]; eac[ax] = pc[ax] - pa[ax];
      ebc[ax] = pc[ax] - pb[ax];
      rap[ax] = pt[ax] - pa[ax]; rbp[ax] = pt[ax] - pb[ax];
      rcp[ax] = pt[ax] - pc[ax];
    end
    s1 = dot3(eab, rap); s2 = dot3(eac, rap);
    s3 = dot3(eab, rbp); s4 = dot3(eac, rbp);
    s5 = dot3(eab, rcp); s6 = dot3(eac, rcp);
    mc = wide_t'(s1) * wide_t'(s4) - wide_t'(s3) * wide_t'(s2);
    mb = wide_t'(s5) * wide_t'(s2) - wide_t'(s1) * wide_t'(s6);
    ma = wide_t'(s3) * wide_t'(s6) - wide_t'(s5) * wide_t'(s4);
    // test order decides ties: vertices and edges before the face
    if (s1 <= 0 && s2 <= 0) begin
      o.region = ptd_pkg::REGION_A;  o.dsq = sq_dist(rap, nil, 0, nil, 0);
    end else if (s3 >= 0 && s4 <= s3) begin
      o.region = ptd_pkg::REGION_B;  o.dsq = sq_dist(rbp, nil, 0, nil, 0);
    end else if (mc <= 0 && s1 >= 0 && s3 <= 0) begin
      ta = ratio_of(wide_t'(s1), wide_t'(s1 - s3), o.degen);
      o.region = ptd_pkg::REGION_AB; o.dsq = sq_dist(rap, eab, ta, nil, 0);
    end else if (s6 >= 0 && s5 <= s6) begin
      o.region = ptd_pkg::REGION_C;  o.dsq = sq_dist(rcp, nil, 0, nil, 0);
    end else if (mb <= 0 && s2 >= 0 && s6 <= 0) begin
      tb = ratio_of(wide_t'(s2), wide_t'(s2 - s6), o.degen);
      o.region = ptd_pkg::REGION_AC; o.dsq = sq_dist(rap, eac, tb, nil, 0);
    end else if (ma <= 0 && (s4 - s3) >= 0 && (s5 - s6) >= 0) begin
      tb = ratio_of(wide_t'(s4 - s3), wide_t'((s4 - s3) + (s5 - s6)), o.degen);
      o.region = ptd_pkg::REGION_BC; o.dsq = sq_dist(rbp, ebc, tb, nil, 0);
    end else begin
      ta = ratio_of(mb, ma + mb + mc, o.degen);
      tb = ratio_of(mc, ma + mb + mc, o.degen);
      o.region = ptd_pkg::REGION_FACE; o.dsq = sq_dist(rap, eab, ta, eac, tb);
    end
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // driving and checking
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    mismatches++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // outputs are registered, so the value seen at the edge is the one shown
  // during the cycle that the edge closes
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_q.pop_front();
        if (dist_squared_o !== want.dsq)
          report_mismatch($sformatf("dist_squared %h, expected %h",
                                    dist_squared_o, want.dsq));
        if (region_o !== want.region)
          report_mismatch($sformatf("region %0d, expected %0d", region_o, want.region));
        if (degenerate_o !== want.degen)
          report_mismatch($sformatf("degenerate %b, expected %b",
                                    degenerate_o, want.degen));
      end
    end
  end

  // holds the beat until the edge that takes it; start stays high afterwards
  task automatic send_beat(coord_t c[12]);
    start <= 1'b1;
    for (int i = 0; i < 12; i++) drv_q[i] <= c[i];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_q = {pending_q, closest_feature(c)};
  endtask

  task automatic pause(int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic coord_t clamp(longint v);
    if (v > CMAX) return coord_t'(CMAX);
    if (v < CMIN) return coord_t'(CMIN);
    return coord_t'(v);
  endfunction

  function automatic longint spread(longint span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // point = A + u*(B-A) + v*(C-A), u and v in quarters so the point can sit
  // in any region
  task automatic send_placed(longint v[9], int u4, int w4);
    coord_t c[12];
    for (int ax = 0; ax < 3; ax++) begin
      c[ax] = clamp(v[ax] + (u4 * (v[3+ax] - v[ax]) + w4 * (v[6+ax] - v[ax])) / 4);
      c[3+ax] = clamp(v[ax]); c[6+ax] = clamp(v[3+ax]); c[9+ax] = clamp(v[6+ax]);
    end
    send_beat(c);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  task automatic test_extremes();
    coord_t c[12];
    for (int i = 0; i < 12; i++) c[i] = coord_t'(CMAX);
    send_beat(c);
    for (int i = 0; i < 12; i++) c[i] = coord_t'(CMIN);
    send_beat(c);
    // far point against a far triangle
    for (int i = 0; i < 3; i++) begin
      c[i] = coord_t'(CMIN); c[3+i] = coord_t'(CMAX);
      c[6+i] = coord_t'(i == 0 ? CMAX : CMIN); c[9+i] = coord_t'(i == 1 ? CMIN : CMAX);
    end
    send_beat(c);
    for (int i = 0; i < 12; i++) c[i] = (i % 2) ? coord_t'(CMAX) : coord_t'(CMIN);
    send_beat(c);
    for (int i = 0; i < 12; i++) c[i] = '0;
    send_beat(c);
  endtask

  // points in each of the seven regions of a fixed triangle, plus two on its boundary
  task automatic test_regions();
    longint shape[9] = '{0, 0, 0, 40000, 0, 3000, 0, 40000, -2000};
    send_placed(shape, -2, -2);
    send_placed(shape, 6, -1);
    send_placed(shape, 2, -3);
    send_placed(shape, -1, 6);
    send_placed(shape, -3, 2);
    send_placed(shape, 3, 3);
    send_placed(shape, 1, 1);
    send_placed(shape, 2, 2);
    send_placed(shape, 4, 0);
  endtask

  // zero length edges and zero area triangles; some of them hit the zero divisor path
  task automatic test_degenerate();
    longint coin[9] = '{1000, -2000, 500, 1000, -2000, 500, 9000, 4000, -700};
    longint line[9] = '{-5000, 0, 100, 5000, 0, 100, 15000, 0, 100};
    longint dot[9]  = '{77, 77, 77, 77, 77, 77, 77, 77, 77};
    send_placed(coin, 2, 2);
    send_placed(coin, 1, -2);
    send_placed(line, 1, 0);
    send_placed(line, 3, 1);
    send_placed(line, -1, 2);
    send_placed(dot, 1, 1);
  endtask

  task automatic test_random(int unsigned count);
    coord_t c[12];
    longint centre[3], span, d[3];
    int unsigned sent, kind, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && sent < count; b++) begin
        kind = $urandom_range(0, 9);
        span = longint'(1) << $urandom_range(2, 18);
        for (int ax = 0; ax < 3; ax++) begin
          centre[ax] = spread(CMAX);
          d[ax] = spread(span);
        end
        for (int ax = 0; ax < 3; ax++) begin
          if (kind < 7) begin
            // well formed: compact triangle with a point around it
            c[3+ax] = clamp(centre[ax] + spread(span));
            c[6+ax] = clamp(centre[ax] + spread(span));
            c[9+ax] = clamp(centre[ax] + spread(span));
            c[ax]   = clamp(centre[ax] + spread(2 * span));
          end else if (kind == 7) begin
            // collinear or coincident vertices
            c[3+ax] = clamp(centre[ax]);
            c[6+ax] = clamp(centre[ax] + d[ax] * $urandom_range(0, 1));
            c[9+ax] = clamp(centre[ax] + d[ax] * ($urandom_range(0, 4) - 2));
            c[ax]   = clamp(centre[ax] + spread(2 * span));
          end else begin
            // full range noise
            for (int v = 0; v < 4; v++) c[3*v+ax] = coord_t'($urandom);
          end
        end
        send_beat(c);
        sent++;
      end
      // the first stretch streams back to back
      if (sent > 100) pause($urandom_range(0, 6));
      if (sent >= count / 2 && sent - burst < count / 2) wait_drained();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_regions();
    pause(3);
    test_degenerate();
    wait_drained();
    test_random(750);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
